FILE: hdl/tensor_monomial_shape_eval_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the shape evaluator
// Concurrent assertion wrappers clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef TENSOR_MONOMIAL_SHAPE_EVAL_CORE_MACROS_SVH
`define TENSOR_MONOMIAL_SHAPE_EVAL_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define TMSE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("tmse assertion failed");
`define TMSE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tmse implication failed");
`define TMSE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tmse next-cycle check failed");
`else
`define TMSE_ASSERT(lbl, prop)
`define TMSE_ASSERT_IMP(lbl, ante, cons)
`define TMSE_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: hdl/tmse_pkg.sv
// ----------------------------------------------------------------------------
// Shape evaluator package
// Fixed-point types, register codes and saturating arithmetic helpers.
// ----------------------------------------------------------------------------
`default_nettype none
package tmse_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int MAX_DEGREE = 3;

  typedef logic signed [31:0] q_t;

  localparam q_t ONE_Q = q_t'(32'd1 << FRAC_BITS);

  localparam logic [2:0] CFG_DIMENSION     = 3'd0;
  localparam logic [2:0] CFG_DEGREE        = 3'd1;
  localparam logic [2:0] CFG_TOTAL_ORDER   = 3'd2;
  localparam logic [2:0] CFG_INVERSE_SCALE = 3'd3;
  localparam logic [2:0] CFG_CENTER_X      = 3'd4;
  localparam logic [2:0] CFG_CENTER_Y      = 3'd5;
  localparam logic [2:0] CFG_CENTER_Z      = 3'd6;

  typedef struct packed {
    logic [1:0] dimension;
    logic [1:0] degree;
    logic       total_order;
    q_t         inverse_scale;
    q_t         center_x;
    q_t         center_y;
    q_t         center_z;
  } cfg_t;

  typedef struct packed {
    logic       load;
    logic       build;
    logic [1:0] axis;
    logic [1:0] pwr;
    logic       stage1;
    logic       stage2;
    logic [1:0] ta;
    logic [1:0] tb;
    logic [1:0] tc;
    logic [5:0] idx;
    logic       last;
  } cmd_t;

  function automatic logic [1:0] eff_dim(input logic [1:0] dimension);
    return (dimension == 2'd0) ? 2'd1 : dimension;
  endfunction

  function automatic q_t mulq_sat(input logic signed [64:0] prod);
    logic signed [64:0] sh;
    sh = prod >>> FRAC_BITS;
    if (sh[64:31] == '0 || sh[64:31] == '1) begin
      return $signed(sh[31:0]);
    end else if (sh[64]) begin
      return $signed({1'b1, 31'b0});
    end else begin
      return $signed({1'b0, {31{1'b1}}});
    end
  endfunction

  function automatic q_t mulq(input q_t a, input q_t b);
    return mulq_sat(65'(a) * 65'(b));
  endfunction

  function automatic q_t scale_sat(input q_t t, input logic [1:0] p);
    logic signed [33:0] t34;
    logic signed [33:0] r;
    t34 = 34'(t);
    case (p)
      2'd2:    r = t34 <<< 1;
      2'd3:    r = t34 + (t34 <<< 1);
      default: r = t34;
    endcase
    if (r[33:31] == '0 || r[33:31] == '1) begin
      return $signed(r[31:0]);
    end else if (r[33]) begin
      return $signed({1'b1, 31'b0});
    end else begin
      return $signed({1'b0, {31{1'b1}}});
    end
  endfunction

endpackage
`default_nettype wire

FILE: hdl/tmse_dp.sv
// ----------------------------------------------------------------------------
// Shape evaluator datapath
// Per-axis power and derivative tables, product stages and result registers.
// ----------------------------------------------------------------------------
`default_nettype none
module tmse_dp
  import tmse_pkg::*;
(
  input  wire logic       clk,
  input  wire cfg_t       cfg,
  input  wire cmd_t       cmd,
  input  wire q_t         in_coord_x,
  input  wire q_t         in_coord_y,
  input  wire q_t         in_coord_z,
  output logic [5:0]      out_shape_index,
  output q_t              out_shape_value,
  output q_t              out_grad_x,
  output q_t              out_grad_y,
  output q_t              out_grad_z,
  output logic            out_last
);

  q_t coord_r [3];
  q_t pw_r [3][4];
  q_t dv_r [3][4];
  q_t u_r;
  q_t prev_r;
  q_t m0_r, m1_r, m2_r;
  q_t val_r, gx_r, gy_r, gz_r;
  logic [5:0] idx_r;
  logic last_r;

  logic [1:0] dim;
  q_t coord_sel, center_sel;
  logic signed [32:0] diff;
  q_t u_nxt, pw_nxt, t_nxt, dv_nxt;
  q_t px, dx, py, dy, pz, dz;

  always_comb begin
    dim = eff_dim(cfg.dimension);
    case (cmd.axis)
      2'd1: begin
        coord_sel  = coord_r[1];
        center_sel = cfg.center_y;
      end
      2'd2: begin
        coord_sel  = coord_r[2];
        center_sel = cfg.center_z;
      end
      default: begin
        coord_sel  = coord_r[0];
        center_sel = cfg.center_x;
      end
    endcase
    diff   = 33'(coord_sel) - 33'(center_sel);
    u_nxt  = mulq_sat(65'(diff) * 65'(cfg.inverse_scale));
    pw_nxt = mulq(prev_r, u_r);
    t_nxt  = mulq(prev_r, cfg.inverse_scale);
    dv_nxt = scale_sat(t_nxt, cmd.pwr);
    px = pw_r[0][cmd.ta];
    dx = dv_r[0][cmd.ta];
    py = pw_r[1][cmd.tb];
    dy = dv_r[1][cmd.tb];
    pz = pw_r[2][cmd.tc];
    dz = dv_r[2][cmd.tc];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      coord_r[0] <= in_coord_x;
      coord_r[1] <= in_coord_y;
      coord_r[2] <= in_coord_z;
    end
    if (cmd.build) begin
      if (cmd.pwr == 2'd0) begin
        pw_r[cmd.axis][0] <= ONE_Q;
        dv_r[cmd.axis][0] <= '0;
        prev_r <= ONE_Q;
        u_r <= u_nxt;
      end else begin
        pw_r[cmd.axis][cmd.pwr] <= pw_nxt;
        dv_r[cmd.axis][cmd.pwr] <= dv_nxt;
        prev_r <= pw_nxt;
      end
    end
    if (cmd.stage1) begin
      if (dim == 2'd1) begin
        m0_r <= px;
        m1_r <= dx;
        m2_r <= '0;
      end else begin
        m0_r <= mulq(px, py);
        m1_r <= mulq(dx, py);
        m2_r <= mulq(px, dy);
      end
    end
    if (cmd.stage2) begin
      if (dim == 2'd3) begin
        val_r <= mulq(m0_r, pz);
        gx_r  <= mulq(m1_r, pz);
        gy_r  <= mulq(m2_r, pz);
        gz_r  <= mulq(m0_r, dz);
      end else begin
        val_r <= m0_r;
        gx_r  <= m1_r;
        gy_r  <= m2_r;
        gz_r  <= '0;
      end
      idx_r  <= cmd.idx;
      last_r <= cmd.last;
    end
  end

  assign out_shape_index = idx_r;
  assign out_shape_value = val_r;
  assign out_grad_x      = gx_r;
  assign out_grad_y      = gy_r;
  assign out_grad_z      = gz_r;
  assign out_last        = last_r;

endmodule
`default_nettype wire

FILE: hdl/tmse_ctrl.sv
// ----------------------------------------------------------------------------
// Shape evaluator controller
// Sequences table build, walks the basis ordering and runs the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none
`include "tensor_monomial_shape_eval_core_macros.svh"
module tmse_ctrl
  import tmse_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cfg_t cfg,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output cmd_t      cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_BUILD = 3'd1;
  localparam logic [2:0] S_TERM1 = 3'd2;
  localparam logic [2:0] S_TERM2 = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  localparam logic [1:0] PH_LOW  = 2'd0;
  localparam logic [1:0] PH_HIGH = 2'd1;
  localparam logic [1:0] PH_DIAG = 2'd2;

  logic [2:0] state_r, state_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic [1:0] pwr_r, pwr_nxt;
  logic [1:0] gi_r, gi_nxt, gj_r, gj_nxt, gk_r, gk_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [5:0] k_r, k_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       last_r, last_nxt;

  logic [1:0] dim, deg;
  logic       tot;
  logic [1:0] g_a, g_b, g_c;
  logic [1:0] l_a, l_b, l_c;
  logic       final_term;
  logic [3:0] sum2, sum3;
  logic       k_adv, j_adv;

  always_comb begin
    dim  = eff_dim(cfg.dimension);
    deg  = cfg.degree;
    tot  = cfg.total_order;
    sum2 = {2'b00, gi_r} + {2'b00, gj_r};
    sum3 = sum2 + {2'b00, gk_r};
    k_adv = (gk_r < deg) && (!tot || sum3 < {2'b00, deg});
    j_adv = (gj_r < deg) && (!tot || sum2 < {2'b00, deg});
    gi_nxt = gi_r;
    gj_nxt = gj_r;
    gk_nxt = gk_r;
    phase_nxt = phase_r;
    g_a = gi_r;
    g_b = 2'd0;
    g_c = 2'd0;
    final_term = (gi_r == deg);
    l_a = deg;
    l_b = (tot) ? 2'd0 : deg;
    l_c = (tot || dim == 2'd2) ? 2'd0 : deg;
    unique case (dim)
      2'd2: begin
        if (tot) begin
          g_a = gj_r;
          g_b = gi_r - gj_r;
          final_term = (gi_r == deg) && (gj_r == gi_r);
          if (gj_r == gi_r) begin
            gi_nxt = gi_r + 2'd1;
            gj_nxt = 2'd0;
          end else begin
            gj_nxt = gj_r + 2'd1;
          end
        end else begin
          final_term = (phase_r == PH_DIAG) && (gi_r == deg);
          case (phase_r)
            PH_LOW: begin
              g_a = gj_r;
              g_b = gi_r;
              if (gj_r == gi_r - 2'd1) begin
                phase_nxt = PH_HIGH;
                gj_nxt = 2'd0;
              end else begin
                gj_nxt = gj_r + 2'd1;
              end
            end
            PH_HIGH: begin
              g_a = gi_r;
              g_b = gj_r;
              if (gj_r == gi_r - 2'd1) begin
                phase_nxt = PH_DIAG;
              end else begin
                gj_nxt = gj_r + 2'd1;
              end
            end
            default: begin
              g_a = gi_r;
              g_b = gi_r;
              gi_nxt = gi_r + 2'd1;
              gj_nxt = 2'd0;
              phase_nxt = PH_LOW;
            end
          endcase
        end
      end
      2'd3: begin
        g_b = gj_r;
        g_c = gk_r;
        final_term = !k_adv && !j_adv && (gi_r == deg);
        if (k_adv) begin
          gk_nxt = gk_r + 2'd1;
        end else if (j_adv) begin
          gk_nxt = 2'd0;
          gj_nxt = gj_r + 2'd1;
        end else begin
          gk_nxt = 2'd0;
          gj_nxt = 2'd0;
          gi_nxt = gi_r + 2'd1;
        end
      end
      default: begin
        gi_nxt = gi_r + 2'd1;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    pwr_nxt       = pwr_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    last_nxt      = last_r;
    cmd        = '0;
    cmd.axis   = axis_r;
    cmd.pwr    = pwr_r;
    cmd.idx    = k_r;
    cmd.last   = final_term;
    if (dim != 2'd1 && k_r == 6'd0) begin
      cmd.ta = l_a;
      cmd.tb = l_b;
      cmd.tc = l_c;
    end else if (dim != 2'd1 && final_term) begin
      cmd.ta = 2'd0;
      cmd.tb = 2'd0;
      cmd.tc = 2'd0;
    end else begin
      cmd.ta = g_a;
      cmd.tb = g_b;
      cmd.tc = g_c;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_BUILD;
          axis_nxt  = 2'd0;
          pwr_nxt   = 2'd0;
          k_nxt     = 6'd0;
        end
      end
      S_BUILD: begin
        cmd.build = 1'b1;
        if (pwr_r == deg) begin
          pwr_nxt = 2'd0;
          if (axis_r == 2'd2) begin
            state_nxt = S_TERM1;
          end else begin
            axis_nxt = axis_r + 2'd1;
          end
        end else begin
          pwr_nxt = pwr_r + 2'd1;
        end
      end
      S_TERM1: begin
        cmd.stage1 = 1'b1;
        state_nxt  = S_TERM2;
      end
      S_TERM2: begin
        cmd.stage2    = 1'b1;
        out_valid_nxt = 1'b1;
        last_nxt      = final_term;
        k_nxt         = k_r + 6'd1;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = last_r ? S_IDLE : S_TERM1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= 2'd0;
      pwr_r       <= 2'd0;
      gi_r        <= 2'd0;
      gj_r        <= 2'd0;
      gk_r        <= 2'd0;
      phase_r     <= PH_DIAG;
      k_r         <= 6'd0;
      out_valid_r <= 1'b0;
      last_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      pwr_r       <= pwr_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
      last_r      <= last_nxt;
      if (state_r == S_IDLE) begin
        gi_r    <= 2'd0;
        gj_r    <= 2'd0;
        gk_r    <= 2'd0;
        phase_r <= PH_DIAG;
      end else if (state_r == S_TERM2) begin
        gi_r    <= gi_nxt;
        gj_r    <= gj_nxt;
        gk_r    <= gk_nxt;
        phase_r <= phase_nxt;
      end
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  `TMSE_ASSERT(a_ready_excl, !(in_ready && out_valid))
  `TMSE_ASSERT_IMP(a_term_range, state_r == S_TERM1, (cmd.ta <= deg) && (cmd.tb <= deg) && (cmd.tc <= deg))
  `TMSE_ASSERT_NXT(a_result_follows, state_r == S_TERM2, out_valid)
  `TMSE_ASSERT_NXT(a_last_frees, out_valid && out_ready && last_r, in_ready)

endmodule
`default_nettype wire

FILE: hdl/tensor_monomial_shape_eval_core.sv
// ----------------------------------------------------------------------------
// Tensor-product monomial shape evaluator
// Emits every scaled-monomial shape function and its gradient for one point.
// ----------------------------------------------------------------------------
//   Channel | Direction | Handshake             | Payload
//   in      | input     | in_valid / in_ready   | in_coord_x, in_coord_y, in_coord_z
//   out     | output    | out_valid / out_ready | index, value, gradient, last
//   cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A point is taken while the block is idle; the axis tables are then built
// one power at a time, for each of the three axes in turn.
// Each shape function then passes through the two product stages into the
// output registers, where it is held until out_ready takes it.
// Reset is synchronous and restores the register defaults.
// A low out_ready holds the current beat and stops the term walk.
`default_nettype none
module tensor_monomial_shape_eval_core
  import tmse_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire q_t          in_coord_x,
  input  wire q_t          in_coord_y,
  input  wire q_t          in_coord_z,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [5:0]       out_shape_index,
  output q_t               out_shape_value,
  output q_t               out_grad_x,
  output q_t               out_grad_y,
  output q_t               out_grad_z,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  cfg_t cfg_r, cfg_nxt;
  cmd_t cmd;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DIMENSION:     cfg_nxt.dimension     = cfg_data[1:0];
        CFG_DEGREE:        cfg_nxt.degree        = cfg_data[1:0];
        CFG_TOTAL_ORDER:   cfg_nxt.total_order   = cfg_data[0];
        CFG_INVERSE_SCALE: cfg_nxt.inverse_scale = $signed(cfg_data);
        CFG_CENTER_X:      cfg_nxt.center_x      = $signed(cfg_data);
        CFG_CENTER_Y:      cfg_nxt.center_y      = $signed(cfg_data);
        CFG_CENTER_Z:      cfg_nxt.center_z      = $signed(cfg_data);
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dimension     <= 2'd1;
      cfg_r.degree        <= 2'd1;
      cfg_r.total_order   <= 1'b0;
      cfg_r.inverse_scale <= ONE_Q;
      cfg_r.center_x      <= '0;
      cfg_r.center_y      <= '0;
      cfg_r.center_z      <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_ready = 1'b1;

  tmse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  tmse_dp u_dp (
    .clk             (clk),
    .cfg             (cfg_r),
    .cmd             (cmd),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .in_coord_z      (in_coord_z),
    .out_shape_index (out_shape_index),
    .out_shape_value (out_shape_value),
    .out_grad_x      (out_grad_x),
    .out_grad_y      (out_grad_y),
    .out_grad_z      (out_grad_z),
    .out_last        (out_last)
  );

endmodule
`default_nettype wire
